@@ rtl/tpd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants for the pump-delay thermostat
// Field widths, action and engine command codes, register indexes and the
// result word carried from the decision core to the output stage.
// ----------------------------------------------------------------------------
package tpd_pkg;

  // Field widths
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned DELAY_W  = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Register defaults
  localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 12'sd200;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 12'sd220;
  localparam logic [DELAY_W-1:0]       ON_DLY_RST   = 24'd5000;
  localparam logic [DELAY_W-1:0]       OFF_DLY_RST  = 24'd5000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_DLY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DLY  = 2'd3;

  // Requested action
  typedef enum logic [1:0] {
    ACT_HEAT  = 2'd0,
    ACT_COOL  = 2'd1,
    ACT_RANGE = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Engine command (code 3 is unused)
  typedef enum logic [1:0] {
    CMD_NOTHING = 2'd0,
    CMD_RUN     = 2'd1,
    CMD_HOLD    = 2'd2
  } cmd_e;

  // Limits and delays as seen by the core
  typedef struct packed {
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic [DELAY_W-1:0]       on_delay;
    logic [DELAY_W-1:0]       off_delay;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [1:0] engine_cmd;
    logic       pump_on;
    logic       drivers_enabled;
  } res_t;

endpackage

@@ rtl/tpd_core.sv @@
// ----------------------------------------------------------------------------
// tpd_core: thermostat decision logic and controller state
// Holds the waiting flags, pump relay state and saturating tick timer, and
// computes the result for the word in the input register in one pass.
// ----------------------------------------------------------------------------
module tpd_core #(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [1:0]                         action_i,
  input  logic signed [tpd_pkg::TEMP_W-1:0]  temperature_i,
  input  tpd_pkg::cfg_t                      cfg_i,
  output tpd_pkg::res_t                      res_o
);

  // Compare width covers both timer and delay registers
  localparam int unsigned CMP_W =
    (TIMER_BITS > tpd_pkg::DELAY_W) ? TIMER_BITS : tpd_pkg::DELAY_W;

  logic                  drv_wait_q, drv_wait_d;
  logic                  pump_wait_q, pump_wait_d;
  logic                  pump_q, pump_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [CMP_W-1:0]      elapsed_x, on_dly_x, off_dly_x;
  logic                  on_done, off_done;
  logic                  le_max, ge_min;
  tpd_pkg::cmd_e         cmd;

  // Saturating tick
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;

  assign elapsed_x = CMP_W'(elapsed_inc);
  assign on_dly_x  = CMP_W'(cfg_i.on_delay);
  assign off_dly_x = CMP_W'(cfg_i.off_delay);
  assign on_done   = elapsed_x > on_dly_x;
  assign off_done  = elapsed_x > off_dly_x;

  assign le_max = temperature_i <= cfg_i.max_temp;
  assign ge_min = temperature_i >= cfg_i.min_temp;

  // Next state and engine command
  always_comb begin
    drv_wait_d  = drv_wait_q;
    pump_wait_d = pump_wait_q;
    pump_d      = pump_q;
    elapsed_d   = elapsed_inc;
    cmd         = tpd_pkg::CMD_NOTHING;
    case (tpd_pkg::action_e'(action_i))
      tpd_pkg::ACT_HEAT: begin
        if (!drv_wait_q) begin
          if (pump_wait_q) begin
            if (on_done) pump_wait_d = 1'b0;
          end else if (le_max) begin
            cmd = tpd_pkg::CMD_RUN;
          end else begin
            cmd         = tpd_pkg::CMD_HOLD;
            drv_wait_d  = 1'b1;
            pump_wait_d = 1'b1;
            elapsed_d   = '0;
          end
        end else begin
          // off-delay check first, then the restart at the low limit
          if (pump_wait_q && off_done) begin
            pump_wait_d = 1'b0;
            pump_d      = 1'b0;
          end
          if (!(temperature_i > cfg_i.min_temp)) begin
            drv_wait_d  = 1'b0;
            pump_d      = 1'b1;
            elapsed_d   = '0;
            pump_wait_d = 1'b1;
          end
        end
      end
      tpd_pkg::ACT_COOL: begin
        cmd = ge_min ? tpd_pkg::CMD_RUN : tpd_pkg::CMD_HOLD;
      end
      tpd_pkg::ACT_RANGE: begin
        cmd = (le_max && ge_min) ? tpd_pkg::CMD_RUN : tpd_pkg::CMD_HOLD;
      end
      default: begin
        cmd = tpd_pkg::CMD_NOTHING;
      end
    endcase
  end

  // Result fields
  assign res_o.engine_cmd      = cmd;
  assign res_o.pump_on         = pump_d;
  assign res_o.drivers_enabled = ~drv_wait_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_wait_q  <= 1'b0;
      pump_wait_q <= 1'b0;
      pump_q      <= 1'b0;
      elapsed_q   <= '0;
    end else if (step_i) begin
      drv_wait_q  <= drv_wait_d;
      pump_wait_q <= pump_wait_d;
      pump_q      <= pump_d;
      elapsed_q   <= elapsed_d;
    end
  end

endmodule

@@ rtl/thermostat_with_pump_delays.sv @@
// ----------------------------------------------------------------------------
// thermostat_with_pump_delays: hysteresis thermostat with pump timing
// One input word per tick; one result word out per input word.
//
//   channel  | dir | tdata (low bit up)                       | tuser
//   s_axis   | in  | action[1:0], temperature[13:2], pad      | -
//   m_axis   | out | engine_cmd[1:0], pump_on, drivers_en, pad| -
//   cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i          | -
//
// A word moves from the input register to the result register once the result
// register is free; one word per cycle sustained while the output is ready.
// A stalled output holds the result register; the input register still takes
// a word while it is empty. rst_ni clears all valids, controller state and
// restores the register defaults.
// ----------------------------------------------------------------------------
module thermostat_with_pump_delays #(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream: action[1:0], temperature[13:2]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,
  // result stream: engine_cmd[1:0], pump_on[2], drivers_enabled[3]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpd_pkg::CFG_W-1:0]      cfg_data_i
);

  logic                              in_v_q;
  logic [1:0]                        action_q;
  logic signed [tpd_pkg::TEMP_W-1:0] temp_q;
  logic                              out_v_q;
  tpd_pkg::res_t                     res_q, res_d;
  tpd_pkg::cfg_t                     cfg_q;
  logic                              advance, step, in_acc;

  // Handshake
  assign advance       = !out_v_q || m_axis_tready;
  assign step          = in_v_q && advance;
  assign s_axis_tready = !in_v_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_temp  <= tpd_pkg::MIN_TEMP_RST;
      cfg_q.max_temp  <= tpd_pkg::MAX_TEMP_RST;
      cfg_q.on_delay  <= tpd_pkg::ON_DLY_RST;
      cfg_q.off_delay <= tpd_pkg::OFF_DLY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpd_pkg::REG_MIN_TEMP: cfg_q.min_temp  <= cfg_data_i[tpd_pkg::TEMP_W-1:0];
        tpd_pkg::REG_MAX_TEMP: cfg_q.max_temp  <= cfg_data_i[tpd_pkg::TEMP_W-1:0];
        tpd_pkg::REG_ON_DLY:   cfg_q.on_delay  <= cfg_data_i;
        tpd_pkg::REG_OFF_DLY:  cfg_q.off_delay <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= s_axis_tdata[1:0];
      temp_q   <= s_axis_tdata[13:2];
    end
  end

  // Decision core
  tpd_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .action_i      (action_q),
    .temperature_i (temp_q),
    .cfg_i         (cfg_q),
    .res_o         (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0000, res_q.drivers_enabled, res_q.pump_on, res_q.engine_cmd};

  // Checks
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_v_q && out_v_q))
    else $error("input blocked without both stages full");

  a_moves_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !out_v_q) |=> out_v_q)
    else $error("word in input register did not advance");

  a_cmd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (res_q.engine_cmd != 2'd3))
    else $error("unused engine command code");

endmodule

@@ verif/thermostat_with_pump_delays_test.sv @@
// ----------------------------------------------------------------------------
// thermostat_with_pump_delays_test: self-checking bench for the thermostat
// A short directed script covers the limit comparisons, the heat hysteresis
// cycle, both pump delays, crossed limits and an unreachable delay. Random
// phases follow, each with new limits and delays and a drifting temperature
// trace. Every result word is checked against an in-bench model of the
// controller, or against a hand-written result on typed script rows, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module thermostat_with_pump_delays_test;

  localparam int N_ROWS      = 30;
  localparam int N_PHASES    = 10;
  localparam int PHASE_WORDS = 130;

  // One result word as it is checked
  typedef struct packed {
    tpd_pkg::cmd_e cmd;
    logic          pump;
    logic          den;
  } word_t;

  // Script row: a register write or an input word, with an optional
  // hand-written result (value is the temperature on word rows)
  typedef struct {
    bit               is_cfg;
    logic [1:0]       idx;
    int               value;
    tpd_pkg::action_e act;
    bit               typed;
    tpd_pkg::cmd_e    cmd;
    bit               pump;
    bit               den;
  } step_row_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // action[1:0], temperature[13:2], pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // engine_cmd[1:0], pump_on, drivers_en, pad
  logic                          cfg_we_i   = 1'b0;
  logic [tpd_pkg::CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [tpd_pkg::CFG_W-1:0]     cfg_data_i = '0;

  // Controller model: limits, delays and state
  logic signed [tpd_pkg::TEMP_W-1:0] min_lim = tpd_pkg::MIN_TEMP_RST;
  logic signed [tpd_pkg::TEMP_W-1:0] max_lim = tpd_pkg::MAX_TEMP_RST;
  logic [tpd_pkg::DELAY_W-1:0]       on_dly  = tpd_pkg::ON_DLY_RST;
  logic [tpd_pkg::DELAY_W-1:0]       off_dly = tpd_pkg::OFF_DLY_RST;
  logic                              heat_waiting = 1'b0;
  logic                              pump_pending = 1'b0;
  logic                              pump_relay   = 1'b0;
  logic [tpd_pkg::DELAY_W-1:0]       tick_count   = '0;

  word_t expected_words[$];
  int    mismatch_count = 0;

  // Temperature trace for the random phases
  int walk_temp = 0;
  bit walk_up   = 1'b1;

  // Receiver stall pattern
  logic [15:0] rx_pattern = '1;
  logic [5:0]  rx_phase   = '0;

  step_row_t script_rows [N_ROWS] = '{
    // after reset: limits 200..220, both delays 5000
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 0, tpd_pkg::ACT_NONE,
      1'b1, tpd_pkg::CMD_NOTHING, 1'b0, 1'b1},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 200, tpd_pkg::ACT_COOL,
      1'b1, tpd_pkg::CMD_RUN, 1'b0, 1'b1},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 199, tpd_pkg::ACT_COOL,
      1'b1, tpd_pkg::CMD_HOLD, 1'b0, 1'b1},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, -2048, tpd_pkg::ACT_COOL,
      1'b1, tpd_pkg::CMD_HOLD, 1'b0, 1'b1},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 2047, tpd_pkg::ACT_COOL,
      1'b1, tpd_pkg::CMD_RUN, 1'b0, 1'b1},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 220, tpd_pkg::ACT_RANGE,
      1'b1, tpd_pkg::CMD_RUN, 1'b0, 1'b1},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 221, tpd_pkg::ACT_RANGE,
      1'b1, tpd_pkg::CMD_HOLD, 1'b0, 1'b1},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 199, tpd_pkg::ACT_RANGE,
      1'b1, tpd_pkg::CMD_HOLD, 1'b0, 1'b1},
    // heat: run, then hold above max
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 220, tpd_pkg::ACT_HEAT,
      1'b1, tpd_pkg::CMD_RUN, 1'b0, 1'b1},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 221, tpd_pkg::ACT_HEAT,
      1'b1, tpd_pkg::CMD_HOLD, 1'b0, 1'b0},
    // waiting, off-delay far away
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 2047, tpd_pkg::ACT_HEAT,
      1'b1, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    // at min: pump restarts
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 200, tpd_pkg::ACT_HEAT,
      1'b1, tpd_pkg::CMD_NOTHING, 1'b1, 1'b1},
    // on-delay pending blocks supervision
    '{1'b0, tpd_pkg::REG_MIN_TEMP, -2048, tpd_pkg::ACT_HEAT,
      1'b1, tpd_pkg::CMD_NOTHING, 1'b1, 1'b1},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 2047, tpd_pkg::ACT_NONE,
      1'b1, tpd_pkg::CMD_NOTHING, 1'b1, 1'b1},
    // short delays: on-delay runs out, off-delay switches the pump off
    '{1'b1, tpd_pkg::REG_ON_DLY, 1, tpd_pkg::ACT_NONE,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b1, tpd_pkg::REG_OFF_DLY, 2, tpd_pkg::ACT_NONE,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 100, tpd_pkg::ACT_HEAT,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 300, tpd_pkg::ACT_HEAT,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 300, tpd_pkg::ACT_HEAT,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 300, tpd_pkg::ACT_HEAT,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 300, tpd_pkg::ACT_HEAT,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 150, tpd_pkg::ACT_HEAT,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    // crossed limits: min above max
    '{1'b1, tpd_pkg::REG_MIN_TEMP, 1250, tpd_pkg::ACT_NONE,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b1, tpd_pkg::REG_MAX_TEMP, -550, tpd_pkg::ACT_NONE,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 0, tpd_pkg::ACT_RANGE,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 1250, tpd_pkg::ACT_COOL,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 0, tpd_pkg::ACT_HEAT,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    // on-delay at the saturated timer value never runs out
    '{1'b1, tpd_pkg::REG_ON_DLY, 16777215, tpd_pkg::ACT_NONE,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 0, tpd_pkg::ACT_HEAT,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0},
    '{1'b0, tpd_pkg::REG_MIN_TEMP, 0, tpd_pkg::ACT_HEAT,
      1'b0, tpd_pkg::CMD_NOTHING, 1'b0, 1'b0}
  };

  thermostat_with_pump_delays dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // One tick of the controller: returns the word it should produce
  function automatic word_t thermo_tick(tpd_pkg::action_e act,
                                        logic signed [tpd_pkg::TEMP_W-1:0] temp);
    word_t w;
    w.cmd = tpd_pkg::CMD_NOTHING;
    // timer saturates
    if (tick_count != '1) tick_count++;
    case (act)
      tpd_pkg::ACT_HEAT: begin
        if (!heat_waiting) begin
          if (pump_pending) begin
            if (tick_count > on_dly) pump_pending = 1'b0;
          end else if (temp <= max_lim) begin
            w.cmd = tpd_pkg::CMD_RUN;
          end else begin
            w.cmd        = tpd_pkg::CMD_HOLD;
            heat_waiting = 1'b1;
            pump_pending = 1'b1;
            tick_count   = '0;
          end
        end else begin
          // off-delay first, then the restart at min
          if (pump_pending && tick_count > off_dly) begin
            pump_pending = 1'b0;
            pump_relay   = 1'b0;
          end
          if (temp <= min_lim) begin
            heat_waiting = 1'b0;
            pump_relay   = 1'b1;
            tick_count   = '0;
            pump_pending = 1'b1;
          end
        end
      end
      tpd_pkg::ACT_COOL: begin
        w.cmd = (temp >= min_lim) ? tpd_pkg::CMD_RUN : tpd_pkg::CMD_HOLD;
      end
      tpd_pkg::ACT_RANGE: begin
        w.cmd = (temp <= max_lim && temp >= min_lim) ? tpd_pkg::CMD_RUN
                                                     : tpd_pkg::CMD_HOLD;
      end
      default: ;
    endcase
    w.pump = pump_relay;
    w.den  = !heat_waiting;
    return w;
  endfunction

  // Drifting temperature with occasional full-range noise
  function automatic logic signed [tpd_pkg::TEMP_W-1:0] next_temp();
    int step;
    if ($urandom_range(0, 6) == 0) return tpd_pkg::TEMP_W'($urandom);
    if (walk_temp > max_lim + 3) walk_up = 1'b0;
    else if (walk_temp < min_lim - 3) walk_up = 1'b1;
    step = $urandom_range(0, 3);
    walk_temp = walk_up ? walk_temp + step : walk_temp - step;
    if (walk_temp > 2047) walk_temp = 2047;
    if (walk_temp < -2048) walk_temp = -2048;
    return tpd_pkg::TEMP_W'(walk_temp);
  endfunction

  // Offer one input word and wait for it to be taken
  task automatic send_word(input tpd_pkg::action_e act,
                           input logic signed [tpd_pkg::TEMP_W-1:0] temp,
                           input bit typed, input word_t typed_word);
    word_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, temp, act};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = thermo_tick(act, temp);
    expected_words.push_back(typed ? typed_word : predicted);
  endtask

  // Wait until every result word has come back
  task automatic drain_results();
    while (expected_words.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpd_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      tpd_pkg::REG_MIN_TEMP: min_lim = data[tpd_pkg::TEMP_W-1:0];
      tpd_pkg::REG_MAX_TEMP: max_lim = data[tpd_pkg::TEMP_W-1:0];
      tpd_pkg::REG_ON_DLY:   on_dly  = data[tpd_pkg::DELAY_W-1:0];
      tpd_pkg::REG_OFF_DLY:  off_dly = data[tpd_pkg::DELAY_W-1:0];
      default: ;
    endcase
  endtask

  // Result check and receiver stalls
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word 0x%02h with nothing expected", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata[1:0] !== want.cmd) begin
          $error("engine_cmd: expected %0d, got %0d", want.cmd, m_axis_tdata[1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[2] !== want.pump) begin
          $error("pump_on: expected %0d, got %0d", want.pump, m_axis_tdata[2]);
          mismatch_count++;
        end
        if (m_axis_tdata[3] !== want.den) begin
          $error("drivers_enabled: expected %0d, got %0d", want.den, m_axis_tdata[3]);
          mismatch_count++;
        end
      end
    end
    // new stall pattern each time rx_phase wraps: none, random, mostly stalled, mostly ready
    rx_phase <= rx_phase + 1'b1;
    if (rx_phase == '1) begin
      case ($urandom_range(0, 3))
        0:       rx_pattern <= '1;
        1:       rx_pattern <= 16'($urandom);
        2:       rx_pattern <= 16'($urandom) & 16'($urandom) | 16'h1;
        default: rx_pattern <= 16'($urandom) | 16'($urandom);
      endcase
    end
    m_axis_tready <= rx_pattern[rx_phase[3:0]];
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    step_row_t        row;
    word_t            typed_word;
    tpd_pkg::action_e act;
    int               lo, hi, pick, burst_left;
    bit               gapless;
    logic [tpd_pkg::DELAY_W-1:0] new_on, new_off;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script
    for (int r = 0; r < N_ROWS; r++) begin
      row = script_rows[r];
      if (row.is_cfg) begin
        s_axis_tvalid <= 1'b0;
        drain_results();
        write_reg(row.idx, tpd_pkg::CFG_W'(row.value));
      end else begin
        typed_word = '{row.cmd, row.pump, row.den};
        send_word(row.act, tpd_pkg::TEMP_W'(row.value), row.typed, typed_word);
      end
    end

    // Random phases, each with its own limits and delays
    for (int phase = 0; phase < N_PHASES; phase++) begin
      s_axis_tvalid <= 1'b0;
      drain_results();
      case (phase)
        0: begin lo = -550;  hi = 1250; new_on = '0; new_off = '0; end
        1: begin lo = -2048; hi = 2047; new_on = '1; new_off = '1; end
        2: begin
          lo = 0; hi = 0; new_on = tpd_pkg::DELAY_W'(3); new_off = '0;
        end
        3: begin
          lo = 300; hi = 100;
          new_on = tpd_pkg::DELAY_W'(5); new_off = tpd_pkg::DELAY_W'(5);
        end
        default: begin
          lo = int'($urandom_range(0, 1800)) - 550;
          if ($urandom_range(0, 7) == 0) hi = lo - int'($urandom_range(0, 20));
          else hi = lo + int'($urandom_range(1, 30));
          new_on  = ($urandom_range(0, 9) == 0) ? '1
                                                : tpd_pkg::DELAY_W'($urandom_range(0, 15));
          new_off = ($urandom_range(0, 9) == 0) ? '1
                                                : tpd_pkg::DELAY_W'($urandom_range(0, 15));
        end
      endcase
      // upper bits of the temperature registers are don't-care
      write_reg(tpd_pkg::REG_MIN_TEMP, {12'($urandom), 12'(lo)});
      write_reg(tpd_pkg::REG_MAX_TEMP, {12'($urandom), 12'(hi)});
      write_reg(tpd_pkg::REG_ON_DLY, new_on);
      write_reg(tpd_pkg::REG_OFF_DLY, new_off);

      walk_temp  = lo;
      gapless    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      act = tpd_pkg::ACT_HEAT;
        else if (pick < 80) act = tpd_pkg::ACT_COOL;
        else if (pick < 90) act = tpd_pkg::ACT_RANGE;
        else                act = tpd_pkg::ACT_NONE;
        send_word(act, next_temp(), 1'b0, '0);
        if ($urandom_range(0, 149) == 0) begin
          // hold off until the pipe is empty
          s_axis_tvalid <= 1'b0;
          drain_results();
        end else if (!gapless && burst_left == 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
          burst_left = $urandom_range(1, 24);
        end else if (burst_left > 0) begin
          burst_left--;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
